// ===== hdl/itv_pkg.sv =====
// shared types, constants and character helpers of the timestamp validator
package itv_pkg;

    localparam int POS_W = 12;

    typedef logic [3:0][7:0] win_t;

    typedef struct packed {
        logic             go;
        logic             view_set;
        logic             clear;
        logic [POS_W-1:0] view_b;
        logic [POS_W-1:0] view_n;
        logic [POS_W-1:0] pos;
    } itv_cmd_t;

    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [POS_W-1:0] len;
        logic [POS_W-1:0] vn;
        win_t             win;
    } itv_stat_t;

    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_UZ    = 8'h5a;
    localparam logic [7:0] CH_LZ    = 8'h7a;

    function automatic logic is_sp(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_dg(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_dg(c) || (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a)
            || (c == 8'h5f);
    endfunction

    function automatic logic [3:0] dval(input logic [7:0] c);
        logic [7:0] d;
        d = c - CH_ZERO;
        return d[3:0];
    endfunction

    function automatic logic [6:0] two_val(input logic [7:0] a, input logic [7:0] b);
        return 7'(dval(a)) * 7'd10 + 7'(dval(b));
    endfunction

    function automatic logic [9:0] three_val(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
        return 10'(dval(a)) * 10'd100 + 10'(dval(b)) * 10'd10 + 10'(dval(c));
    endfunction

endpackage

// ===== hdl/itv_dp.sv =====
// datapath: text memory, length and overflow, trimmed view and four-byte window fetch
module itv_dp #(
    parameter int MAX_LEN = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [7:0]        wr_byte,
    input  itv_pkg::itv_cmd_t cmd,
    output itv_pkg::itv_stat_t stat
);
    import itv_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 1);

    logic [7:0]       mem [MAX_LEN];
    logic [LW-1:0]    len_reg;
    logic             ovf_reg;
    logic [LW-1:0]    vb_reg;
    logic [LW-1:0]    vn_reg;
    logic             act_reg;
    logic [2:0]       cnt_reg;
    logic [7:0]       rd_reg;
    logic             rin_reg;
    logic             rv_reg;
    logic [1:0]       rslot_reg;
    logic             done_reg;
    win_t             win_reg;
    logic [POS_W-1:0] off;
    logic [POS_W-1:0] abs_addr;
    logic             inr;

    assign off      = cmd.pos + POS_W'(cnt_reg);
    assign inr      = off < POS_W'(vn_reg);
    assign abs_addr = POS_W'(vb_reg) + off;

    always_ff @(posedge aclk) begin
        if (wr_en && (len_reg < LW'(MAX_LEN))) begin
            mem[len_reg[AW-1:0]] <= wr_byte;
        end
        if (act_reg && !cnt_reg[2]) begin
            rd_reg <= mem[abs_addr[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            vb_reg    <= '0;
            vn_reg    <= '0;
            act_reg   <= 1'b0;
            cnt_reg   <= '0;
            rv_reg    <= 1'b0;
            rin_reg   <= 1'b0;
            rslot_reg <= '0;
            done_reg  <= 1'b0;
            win_reg   <= '0;
        end else begin
            if (cmd.clear) begin
                len_reg <= '0;
                ovf_reg <= 1'b0;
            end else if (wr_en) begin
                if (len_reg < LW'(MAX_LEN)) begin
                    len_reg <= len_reg + LW'(1);
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.view_set) begin
                vb_reg <= cmd.view_b[LW-1:0];
                vn_reg <= cmd.view_n[LW-1:0];
            end
            if (cmd.go) begin
                act_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (act_reg) begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg[2]) begin
                    act_reg <= 1'b0;
                end
            end
            rv_reg    <= act_reg && !cnt_reg[2];
            rin_reg   <= inr;
            rslot_reg <= cnt_reg[1:0];
            if (rv_reg) begin
                win_reg[rslot_reg] <= rin_reg ? rd_reg : 8'd0;
            end
            done_reg <= rv_reg && (rslot_reg == 2'd3);
        end
    end

    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;
    assign stat.len  = POS_W'(len_reg);
    assign stat.vn   = POS_W'(vn_reg);
    assign stat.win  = win_reg;

endmodule

// ===== hdl/itv_ctrl.sv =====
// controller: beat intake, trimming and the ordered grammar checks
module itv_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_is_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_is_valid,
    output logic               m_overflow,
    output itv_pkg::itv_cmd_t  cmd,
    input  itv_pkg::itv_stat_t stat
);
    import itv_pkg::*;

    typedef enum logic [4:0] {
        ST_COLLECT, ST_START, ST_FETCH, ST_TB, ST_TE, ST_Y0, ST_Y1, ST_Y2,
        ST_TRY, ST_MD0, ST_MD1, ST_WK0, ST_WK1, ST_ORD, ST_TP, ST_TC0,
        ST_TC24A, ST_TC24B, ST_TCM, ST_FR0, ST_FR1, ST_TCS, ST_TCF, ST_ZN0,
        ST_ZN1, ST_ZN2, ST_END, ST_KFAIL, ST_OUT
    } state_t;

    state_t           state_reg, state_next;
    state_t           ret_reg, ret_next;
    state_t           fret_reg, fret_next;
    logic [POS_W-1:0] p_reg, p_next;
    logic [POS_W-1:0] mark_reg, mark_next;
    logic [POS_W-1:0] k_reg, k_next;
    logic [1:0]       kind_reg, kind_next;
    logic             dash_reg, dash_next;
    logic             colon_reg, colon_next;
    logic             rej_reg, rej_next;
    logic             got_reg, got_next;
    logic             valid_reg, valid_next;
    logic             ovf_reg, ovf_next;
    logic             go_reg, go_next;
    logic             vset_reg, vset_next;
    logic [POS_W-1:0] vb_reg, vb_next;
    logic [POS_W-1:0] vn_reg, vn_next;

    logic [7:0] w0, w1, w2, w3;
    logic [POS_W-1:0] vn;
    logic [2:0] lead;
    logic [7:0] stop_c;
    logic [POS_W-1:0] np;

    assign w0 = stat.win[0];
    assign w1 = stat.win[1];
    assign w2 = stat.win[2];
    assign w3 = stat.win[3];
    assign vn = stat.vn;

    always_comb begin
        if (!is_dg(w0)) begin
            lead = 3'd0;
        end else if (!is_dg(w1)) begin
            lead = 3'd1;
        end else if (!is_dg(w2)) begin
            lead = 3'd2;
        end else if (!is_dg(w3)) begin
            lead = 3'd3;
        end else begin
            lead = 3'd4;
        end
        stop_c = stat.win[lead[1:0]];
    end

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        fret_next  = fret_reg;
        p_next     = p_reg;
        mark_next  = mark_reg;
        k_next     = k_reg;
        kind_next  = kind_reg;
        dash_next  = dash_reg;
        colon_next = colon_reg;
        rej_next   = rej_reg;
        got_next   = got_reg;
        valid_next = valid_reg;
        ovf_next   = ovf_reg;
        go_next    = 1'b0;
        vset_next  = 1'b0;
        vb_next    = vb_reg;
        vn_next    = vn_reg;
        np         = p_reg;
        unique case (state_reg)
            ST_COLLECT: begin
                if (s_valid && s_is_last) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (stat.ovf) begin
                    valid_next = 1'b0;
                    ovf_next   = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    vset_next  = 1'b1;
                    vb_next    = '0;
                    vn_next    = stat.len;
                    p_next     = '0;
                    go_next    = 1'b1;
                    ret_next   = ST_TB;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (stat.done) begin
                    state_next = ret_reg;
                end
            end
            ST_TB: begin
                if (p_reg == stat.len) begin
                    valid_next = 1'b0;
                    ovf_next   = 1'b0;
                    state_next = ST_OUT;
                end else if (is_sp(w0)) begin
                    p_next = p_reg + POS_W'(1);
                    go_next = 1'b1;
                    ret_next = ST_TB;
                    state_next = ST_FETCH;
                end else begin
                    mark_next = p_reg;
                    p_next = stat.len - POS_W'(1);
                    go_next = 1'b1;
                    ret_next = ST_TE;
                    state_next = ST_FETCH;
                end
            end
            ST_TE: begin
                if (p_reg != mark_reg && is_sp(w0)) begin
                    p_next = p_reg - POS_W'(1);
                    ret_next = ST_TE;
                end else begin
                    vset_next = 1'b1;
                    vb_next = mark_reg;
                    vn_next = p_reg + POS_W'(1) - mark_reg;
                    p_next = '0;
                    ret_next = ST_Y0;
                end
                go_next = 1'b1;
                state_next = ST_FETCH;
            end
            ST_Y0: begin
                p_next = (w0 == CH_PLUS || w0 == CH_MINUS) ? POS_W'(1) : '0;
                go_next = 1'b1;
                ret_next = ST_Y1;
                state_next = ST_FETCH;
            end
            ST_Y1: begin
                if (is_dg(w0) && is_dg(w1) && is_dg(w2) && is_dg(w3)) begin
                    p_next = p_reg + POS_W'(4);
                    go_next = 1'b1;
                    ret_next = ST_Y2;
                    state_next = ST_FETCH;
                end else begin
                    valid_next = 1'b0;
                    ovf_next   = 1'b0;
                    state_next = ST_OUT;
                end
            end
            ST_Y2: begin
                if (is_dg(w0) && is_dg(w1) && !is_word(w2)) begin
                    valid_next = 1'b0;
                    ovf_next   = 1'b0;
                    state_next = ST_OUT;
                end else if (p_reg == vn) begin
                    valid_next = 1'b1;
                    ovf_next   = 1'b0;
                    state_next = ST_OUT;
                end else begin
                    dash_next = (w0 == CH_MINUS);
                    mark_next = p_reg + ((w0 == CH_MINUS) ? POS_W'(1) : '0);
                    kind_next = 2'd0;
                    state_next = ST_TRY;
                end
            end
            ST_TRY: begin
                p_next = mark_reg;
                go_next = 1'b1;
                state_next = ST_FETCH;
                case (kind_reg)
                    2'd0:    ret_next = ST_MD0;
                    2'd1:    ret_next = ST_WK0;
                    default: ret_next = ST_ORD;
                endcase
            end
            ST_MD0: begin
                if (is_dg(w0) && is_dg(w1) && two_val(w0, w1) >= 7'd1
                        && two_val(w0, w1) <= 7'd12) begin
                    p_next = p_reg + POS_W'(2);
                    go_next = 1'b1;
                    ret_next = ST_MD1;
                    state_next = ST_FETCH;
                end else begin
                    state_next = ST_KFAIL;
                end
            end
            ST_MD1: begin
                if (dash_reg) begin
                    if (w0 == CH_MINUS && is_dg(w1) && is_dg(w2)
                            && two_val(w1, w2) >= 7'd1 && two_val(w1, w2) <= 7'd31) begin
                        np = p_reg + POS_W'(3);
                    end
                end else if (is_dg(w0) && is_dg(w1) && two_val(w0, w1) >= 7'd1
                        && two_val(w0, w1) <= 7'd31) begin
                    np = p_reg + POS_W'(2);
                end
                p_next = np;
                go_next = 1'b1;
                ret_next = ST_TP;
                state_next = ST_FETCH;
            end
            ST_WK0: begin
                if (w0 == CH_W && is_dg(w1) && is_dg(w2) && two_val(w1, w2) <= 7'd52) begin
                    p_next = p_reg + POS_W'(3);
                    go_next = 1'b1;
                    ret_next = ST_WK1;
                    state_next = ST_FETCH;
                end else begin
                    state_next = ST_KFAIL;
                end
            end
            ST_WK1: begin
                go_next = 1'b1;
                ret_next = ST_TP;
                state_next = ST_FETCH;
                if (p_reg < vn) begin
                    if (w0 == CH_MINUS) begin
                        if (p_reg + POS_W'(1) < vn) begin
                            if (w1 < CH_ONE || w1 > CH_SEVEN) begin
                                go_next = 1'b0;
                                state_next = ST_KFAIL;
                            end else begin
                                p_next = p_reg + POS_W'(2);
                            end
                        end
                    end else if (w0 >= CH_ONE && w0 <= CH_SEVEN) begin
                        p_next = p_reg + POS_W'(1);
                    end
                end
            end
            ST_ORD: begin
                if (is_dg(w0) && is_dg(w1) && is_dg(w2) && three_val(w0, w1, w2) >= 10'd1
                        && three_val(w0, w1, w2) <= 10'd366) begin
                    p_next = p_reg + POS_W'(3);
                    go_next = 1'b1;
                    ret_next = ST_TP;
                    state_next = ST_FETCH;
                end else begin
                    state_next = ST_KFAIL;
                end
            end
            ST_TP: begin
                if (p_reg >= vn || (w0 != CH_T && !is_sp(w0))) begin
                    state_next = ST_END;
                end else if (p_reg + POS_W'(1) >= vn) begin
                    p_next = p_reg + POS_W'(1);
                    state_next = ST_END;
                end else begin
                    k_next = p_reg + POS_W'(1);
                    p_next = p_reg + POS_W'(1);
                    go_next = 1'b1;
                    ret_next = ST_TC0;
                    state_next = ST_FETCH;
                end
            end
            ST_TC0: begin
                if (!(is_dg(w0) && is_dg(w1)) || two_val(w0, w1) > 7'd24) begin
                    state_next = ST_TCF;
                end else begin
                    p_next = p_reg + POS_W'(2);
                    go_next = 1'b1;
                    ret_next = (two_val(w0, w1) == 7'd24) ? ST_TC24A : ST_TCM;
                    state_next = ST_FETCH;
                end
            end
            ST_TC24A: begin
                p_next = p_reg + ((w0 == CH_COLON) ? POS_W'(1) : '0);
                go_next = 1'b1;
                ret_next = ST_TC24B;
                state_next = ST_FETCH;
            end
            ST_TC24B: begin
                if (w0 != CH_ZERO || w1 != CH_ZERO) begin
                    state_next = ST_TCF;
                end else begin
                    colon_next = 1'b0;
                    rej_next = 1'b1;
                    fret_next = ST_TCS;
                    p_next = p_reg + POS_W'(2);
                    go_next = 1'b1;
                    ret_next = ST_FR0;
                    state_next = ST_FETCH;
                end
            end
            ST_TCM: begin
                colon_next = 1'b0;
                rej_next = 1'b1;
                fret_next = ST_TCS;
                go_next = 1'b1;
                ret_next = ST_FR0;
                state_next = ST_FETCH;
                if (w0 == CH_COLON && is_dg(w1) && is_dg(w2)) begin
                    colon_next = 1'b1;
                    p_next = p_reg + POS_W'(3);
                    if (two_val(w1, w2) > 7'd59) begin
                        go_next = 1'b0;
                        state_next = ST_TCF;
                    end
                end else if (is_dg(w0) && is_dg(w1)) begin
                    p_next = p_reg + POS_W'(2);
                    if (two_val(w0, w1) > 7'd59) begin
                        go_next = 1'b0;
                        state_next = ST_TCF;
                    end
                end
            end
            ST_FR0: begin
                if (w0 != CH_DOT && w0 != CH_COMMA) begin
                    state_next = fret_reg;
                end else begin
                    got_next = 1'b0;
                    p_next = p_reg + POS_W'(1);
                    go_next = 1'b1;
                    ret_next = ST_FR1;
                    state_next = ST_FETCH;
                end
            end
            ST_FR1: begin
                if (lead == 3'd4) begin
                    got_next = 1'b1;
                    p_next = p_reg + POS_W'(4);
                    go_next = 1'b1;
                    ret_next = ST_FR1;
                    state_next = ST_FETCH;
                end else if (!(got_reg || lead != 3'd0) || (rej_reg && stop_c == CH_COLON)) begin
                    state_next = ST_TCF;
                end else begin
                    p_next = p_reg + POS_W'(lead);
                    go_next = 1'b1;
                    ret_next = fret_reg;
                    state_next = ST_FETCH;
                end
            end
            ST_TCS: begin
                rej_next = 1'b0;
                fret_next = ST_ZN0;
                state_next = ST_ZN0;
                if (colon_reg) begin
                    if (w0 == CH_COLON) begin
                        if (!(is_dg(w1) && is_dg(w2)) || two_val(w1, w2) > 7'd59) begin
                            state_next = ST_TCF;
                        end else begin
                            p_next = p_reg + POS_W'(3);
                            go_next = 1'b1;
                            ret_next = ST_FR0;
                            state_next = ST_FETCH;
                        end
                    end
                end else if (is_dg(w0) && is_dg(w1)) begin
                    if (two_val(w0, w1) > 7'd59) begin
                        state_next = ST_TCF;
                    end else begin
                        p_next = p_reg + POS_W'(2);
                        go_next = 1'b1;
                        ret_next = ST_FR0;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_TCF: begin
                p_next = k_reg;
                go_next = 1'b1;
                ret_next = ST_ZN0;
                state_next = ST_FETCH;
            end
            ST_ZN0: begin
                if (p_reg >= vn) begin
                    state_next = ST_END;
                end else if (w0 == CH_UZ || w0 == CH_LZ) begin
                    p_next = p_reg + POS_W'(1);
                    state_next = ST_END;
                end else if (w0 != CH_PLUS && w0 != CH_MINUS) begin
                    state_next = ST_END;
                end else if (!(is_dg(w1) && is_dg(w2)) || two_val(w1, w2) > 7'd23) begin
                    state_next = ST_KFAIL;
                end else begin
                    p_next = p_reg + POS_W'(3);
                    go_next = 1'b1;
                    ret_next = ST_ZN1;
                    state_next = ST_FETCH;
                end
            end
            ST_ZN1: begin
                p_next = p_reg + ((w0 == CH_COLON) ? POS_W'(1) : '0);
                go_next = 1'b1;
                ret_next = ST_ZN2;
                state_next = ST_FETCH;
            end
            ST_ZN2: begin
                state_next = ST_END;
                if (is_dg(w0) && is_dg(w1)) begin
                    if (two_val(w0, w1) > 7'd59) begin
                        state_next = ST_KFAIL;
                    end else begin
                        p_next = p_reg + POS_W'(2);
                    end
                end
            end
            ST_END: begin
                if (p_reg == vn) begin
                    valid_next = 1'b1;
                    ovf_next   = 1'b0;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_KFAIL;
                end
            end
            ST_KFAIL: begin
                if (kind_reg == 2'd2) begin
                    valid_next = 1'b0;
                    ovf_next   = 1'b0;
                    state_next = ST_OUT;
                end else begin
                    kind_next = kind_reg + 2'd1;
                    state_next = ST_TRY;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_COLLECT;
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COLLECT;
            ret_reg   <= ST_COLLECT;
            fret_reg  <= ST_COLLECT;
            p_reg     <= '0;
            mark_reg  <= '0;
            k_reg     <= '0;
            kind_reg  <= '0;
            dash_reg  <= 1'b0;
            colon_reg <= 1'b0;
            rej_reg   <= 1'b0;
            got_reg   <= 1'b0;
            valid_reg <= 1'b0;
            ovf_reg   <= 1'b0;
            go_reg    <= 1'b0;
            vset_reg  <= 1'b0;
            vb_reg    <= '0;
            vn_reg    <= '0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            fret_reg  <= fret_next;
            p_reg     <= p_next;
            mark_reg  <= mark_next;
            k_reg     <= k_next;
            kind_reg  <= kind_next;
            dash_reg  <= dash_next;
            colon_reg <= colon_next;
            rej_reg   <= rej_next;
            got_reg   <= got_next;
            valid_reg <= valid_next;
            ovf_reg   <= ovf_next;
            go_reg    <= go_next;
            vset_reg  <= vset_next;
            vb_reg    <= vb_next;
            vn_reg    <= vn_next;
        end
    end

    assign s_ready    = (state_reg == ST_COLLECT);
    assign m_valid    = (state_reg == ST_OUT);
    assign m_is_valid = valid_reg;
    assign m_overflow = ovf_reg;

    assign cmd.go       = go_reg;
    assign cmd.view_set = vset_reg;
    assign cmd.clear    = (state_reg == ST_OUT) && m_ready;
    assign cmd.view_b   = vb_reg;
    assign cmd.view_n   = vn_reg;
    assign cmd.pos      = p_reg;

endmodule

// ===== hdl/iso8601_timestamp_validator.sv =====
// top level of the timestamp validator: controller and datapath
// Text beats are taken one per cycle into a MAX_LEN-byte store; the beat flagged
// is_last ends the text and one verdict beat follows. No new text beat is taken
// until that verdict beat has gone. After the last beat the block trims blanks and
// parses the text by fetching four-byte windows from the store through its single
// read port: one fetch per leading or trailing blank, plus the fetches of the parse
// (some 10 to 40 fetches for typical stamps, more for long fractions and for texts
// that fail over to a later date form). A text over MAX_LEN bytes gives is_valid 0
// and overflow 1 with no parse.
module iso8601_timestamp_validator #(
    parameter int MAX_LEN = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,
    input  logic       s_is_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_is_valid,
    output logic       m_overflow
);
    import itv_pkg::*;

    itv_cmd_t  cmd;
    itv_stat_t stat;
    logic      wr_en;

    assign wr_en = s_valid && s_ready;

    itv_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_is_last  (s_is_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_is_valid (m_is_valid),
        .m_overflow (m_overflow),
        .cmd        (cmd),
        .stat       (stat)
    );

    itv_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_byte (s_text_byte),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench of the timestamp validator: directed table, random texts, verdict check
module tb_top;
    import itv_pkg::*;

    localparam int STORE_LEN = 64;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [7:0] b;
        bit         last;
        int         typed;
    } beat_t;

    typedef struct {
        bit valid;
        bit ovf;
    } verdict_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_text_byte = 8'd0;
    logic       s_is_last = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_is_valid;
    logic       m_overflow;

    beat_t      text_beats[$];
    verdict_t   expected_verdicts[$];
    logic [7:0] txt[$];
    beat_t      cur_beat;
    int         fails = 0;
    int         cyc = 0;
    int         stall_cnt = 0;
    bit         calm;

    logic [7:0] held[STORE_LEN];
    int         held_len = 0;
    bit         held_ovf = 0;
    int         vb, vn;

    iso8601_timestamp_validator #(.MAX_LEN(STORE_LEN)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_text_byte(s_text_byte), .s_is_last(s_is_last),
        .m_valid(m_valid), .m_ready(m_ready), .m_is_valid(m_is_valid), .m_overflow(m_overflow)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic bit blank_ch(int c);
        return c == 32 || (c >= 9 && c <= 13);
    endfunction

    function automatic bit digit_ch(int c);
        return c >= 48 && c <= 57;
    endfunction

    function automatic bit word_ch(int c);
        return digit_ch(c) || (c >= 65 && c <= 90) || (c >= 97 && c <= 122) || c == 95;
    endfunction

    function automatic int ch(int k);
        if (k >= vn) return 0;
        if (vb + k >= STORE_LEN) return 0;
        return held[vb + k];
    endfunction

    function automatic bit dg(int k);
        return k < vn && digit_ch(ch(k));
    endfunction

    function automatic bit digits(inout int i, input int n, inout int val);
        int v;
        v = 0;
        if (i + n > vn) return 0;
        for (int k = 0; k < n; k++) begin
            if (!digit_ch(ch(i + k))) return 0;
            v = v * 10 + ch(i + k) - 48;
        end
        i += n;
        val = v;
        return 1;
    endfunction

    function automatic bit fraction(inout int i, input bit rc);
        int p, s, c;
        if (i >= vn) return 1;
        c = ch(i);
        if (c != CH_DOT && c != CH_COMMA) return 1;
        p = i + 1;
        s = p;
        while (dg(p)) p++;
        i = p;
        if (p == s) return 0;
        if (rc && p < vn && ch(p) == CH_COLON) return 0;
        return 1;
    endfunction

    function automatic bit zone_ok(inout int ip);
        int i, c, h, m;
        i = ip;
        h = 0;
        m = 0;
        if (i >= vn) return 1;
        c = ch(i);
        if (c == CH_UZ || c == CH_LZ) begin
            ip = i + 1;
            return 1;
        end
        if (c != CH_PLUS && c != CH_MINUS) return 1;
        i++;
        if (!digits(i, 2, h)) return 0;
        if (h > 23) return 0;
        if (i < vn && ch(i) == CH_COLON) i++;
        if (i + 2 <= vn && dg(i) && dg(i + 1)) begin
            void'(digits(i, 2, m));
            if (m > 59) return 0;
        end
        ip = i;
        return 1;
    endfunction

    function automatic bit clock_ok(inout int ip);
        int i, s, j, hour, v;
        bit colon_sec;
        i = ip;
        hour = 0;
        v = 0;
        colon_sec = 0;
        if (i + 2 > vn || !dg(i) || !dg(i + 1)) return 0;
        s = i;
        void'(digits(i, 2, hour));
        if (hour > 24) return 0;
        if (hour == 24) begin
            if (i < vn && ch(i) == CH_COLON) i++;
            if (i + 2 > vn || ch(i) != CH_ZERO || ch(i + 1) != CH_ZERO) return 0;
            i += 2;
            if (!fraction(i, 1)) return 0;
        end else begin
            j = i;
            if (j < vn && ch(j) == CH_COLON && j + 2 < vn && dg(j + 1) && dg(j + 2)) begin
                j++;
                void'(digits(j, 2, v));
                if (v > 59) return 0;
                colon_sec = 1;
            end else if (j + 2 <= vn && dg(j) && dg(j + 1)) begin
                void'(digits(j, 2, v));
                if (v > 59) return 0;
            end
            i = j;
            if (!fraction(i, 1)) return 0;
        end
        if (colon_sec) begin
            if (i < vn && ch(i) == CH_COLON) begin
                i++;
                if (!digits(i, 2, v)) return 0;
                if (v > 59) return 0;
                if (!fraction(i, 0)) return 0;
            end
        end else if (i + 2 <= vn && dg(i) && dg(i + 1)) begin
            void'(digits(i, 2, v));
            if (v > 59) return 0;
            if (!fraction(i, 0)) return 0;
        end
        if (i == s) return 0;
        ip = i;
        return 1;
    endfunction

    function automatic bit time_ok(inout int kp);
        int k, j, c;
        k = kp;
        if (k >= vn) return 1;
        c = ch(k);
        if (c != CH_T && !blank_ch(c)) return 1;
        k++;
        if (k >= vn) begin
            kp = k;
            return 1;
        end
        j = k;
        if (clock_ok(j)) k = j;
        if (!zone_ok(k)) return 0;
        kp = k;
        return 1;
    endfunction

    function automatic bit month_day_ok(inout int jp, input bit dash);
        int j, k, mo, d;
        bit possible;
        j = jp;
        mo = 0;
        d = 0;
        if (!digits(j, 2, mo)) return 0;
        if (mo < 1 || mo > 12) return 0;
        if (dash) possible = j < vn && ch(j) == CH_MINUS && j + 2 < vn && dg(j + 1) && dg(j + 2);
        else possible = j + 2 <= vn && dg(j) && dg(j + 1);
        if (possible) begin
            k = dash ? j + 1 : j;
            if (digits(k, 2, d) && d >= 1 && d <= 31) begin
                jp = k;
                return 1;
            end
        end
        jp = j;
        return 1;
    endfunction

    function automatic bit week_ok(inout int jp);
        int j, w, d;
        j = jp;
        w = 0;
        if (j >= vn || ch(j) != CH_W) return 0;
        j++;
        if (!digits(j, 2, w)) return 0;
        if (w > 52) return 0;
        if (j < vn) begin
            if (ch(j) == CH_MINUS) begin
                if (j + 1 < vn) begin
                    d = ch(j + 1);
                    if (d < CH_ONE || d > CH_SEVEN) return 0;
                    j += 2;
                end
            end else begin
                d = ch(j);
                if (d >= CH_ONE && d <= CH_SEVEN) j++;
            end
        end
        jp = j;
        return 1;
    endfunction

    function automatic bit date_form_ok(int i, int kind, bit dash);
        int j, v;
        bit ok;
        j = i;
        v = 0;
        if (kind == 0) ok = month_day_ok(j, dash);
        else if (kind == 1) ok = week_ok(j);
        else ok = digits(j, 3, v) && v >= 1 && v <= 366;
        if (!ok) return 0;
        if (!time_ok(j)) return 0;
        return j == vn;
    endfunction

    function automatic bit stamp_verdict();
        int i, y;
        bit dash;
        i = 0;
        y = 0;
        dash = 0;
        if (i < vn && (ch(i) == CH_PLUS || ch(i) == CH_MINUS)) i++;
        if (!digits(i, 4, y)) return 0;
        if (i + 2 <= vn && dg(i) && dg(i + 1)) begin
            if (i + 2 == vn) return 0;
            if (!word_ch(ch(i + 2))) return 0;
        end
        if (i == vn) return 1;
        if (ch(i) == CH_MINUS) begin
            dash = 1;
            i++;
        end
        for (int kind = 0; kind < 3; kind++)
            if (date_form_ok(i, kind, dash)) return 1;
        return 0;
    endfunction

    task automatic take_beat(beat_t bt);
        verdict_t vd;
        int b, e;
        if (held_len < STORE_LEN) begin
            held[held_len] = bt.b;
            held_len++;
        end else begin
            held_ovf = 1;
        end
        if (bt.last) begin
            vd.ovf = held_ovf;
            vd.valid = 0;
            if (!held_ovf) begin
                b = 0;
                while (b < held_len && blank_ch(held[b])) b++;
                if (b == held_len) begin
                    vb = 0;
                    vn = 0;
                end else begin
                    e = held_len - 1;
                    while (e != b && blank_ch(held[e])) e--;
                    vb = b;
                    vn = e + 1 - b;
                end
                vd.valid = stamp_verdict();
            end
            if (bt.typed >= 0) begin
                vd.valid = bt.typed[0];
                vd.ovf = bt.typed[1];
            end
            expected_verdicts.push_back(vd);
            held_len = 0;
            held_ovf = 0;
        end
    endtask

    task automatic queue_text(int typed);
        beat_t bt;
        foreach (txt[k]) begin
            bt.b = txt[k];
            bt.last = (k == txt.size() - 1);
            bt.typed = bt.last ? typed : -1;
            text_beats.push_back(bt);
        end
    endtask

    task automatic put_num(int v, int n);
        for (int k = n - 1; k >= 0; k--) txt.push_back(8'(48 + (v / (10 ** k)) % 10));
    endtask

    task automatic put_blanks();
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n) txt.push_back(($urandom_range(0, 1) == 0) ? 8'd32 : 8'($urandom_range(9, 13)));
    endtask

    task automatic make_stamp();
        int form, r;
        txt.delete();
        put_blanks();
        r = $urandom_range(0, 5);
        if (r == 0) txt.push_back(CH_PLUS);
        if (r == 1) txt.push_back(CH_MINUS);
        put_num($urandom_range(0, 9999), 4);
        form = $urandom_range(0, 4);
        if (form != 0 && $urandom_range(0, 2) != 0) txt.push_back(CH_MINUS);
        case (form)
            1: begin
                put_num($urandom_range(0, 3) == 0 ? $urandom_range(0, 99) : $urandom_range(1, 12), 2);
                if ($urandom_range(0, 2) != 0) begin
                    if ($urandom_range(0, 1) == 0) txt.push_back(CH_MINUS);
                    put_num($urandom_range(0, 3) == 0 ? $urandom_range(0, 99)
                                                      : $urandom_range(1, 31), 2);
                end
            end
            2: begin
                txt.push_back(CH_W);
                put_num($urandom_range(0, 60), 2);
                r = $urandom_range(0, 3);
                if (r == 1) txt.push_back(CH_MINUS);
                if (r != 0) txt.push_back(8'($urandom_range(48, 57)));
            end
            3: put_num($urandom_range(0, 400), 3);
            4: put_num($urandom_range(0, 99), 2);
            default: ;
        endcase
        if (form != 0 && $urandom_range(0, 2) != 0) begin
            txt.push_back(($urandom_range(0, 3) == 0) ? 8'd32 : CH_T);
            put_num($urandom_range(0, 5) == 0 ? 24 : $urandom_range(0, 25), 2);
            r = $urandom_range(0, 3);
            if (r != 0) begin
                if (r != 1) txt.push_back(CH_COLON);
                put_num($urandom_range(0, 62), 2);
                if ($urandom_range(0, 1) == 0) begin
                    if (r != 1) txt.push_back(CH_COLON);
                    put_num($urandom_range(0, 62), 2);
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                txt.push_back(($urandom_range(0, 1) == 0) ? CH_DOT : CH_COMMA);
                repeat ($urandom_range(0, 5)) txt.push_back(8'($urandom_range(48, 57)));
            end
            r = $urandom_range(0, 4);
            if (r == 1) txt.push_back(CH_UZ);
            if (r == 2) txt.push_back(CH_LZ);
            if (r >= 3) begin
                txt.push_back(r == 3 ? CH_PLUS : CH_MINUS);
                put_num($urandom_range(0, 25), 2);
                if ($urandom_range(0, 1) == 0) txt.push_back(CH_COLON);
                if ($urandom_range(0, 2) != 0) put_num($urandom_range(0, 62), 2);
            end
        end
        put_blanks();
        if ($urandom_range(0, 4) == 0)
            txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0) txt.delete($urandom_range(0, txt.size() - 1));
        if (txt.size() == 0) txt.push_back(8'd32);
    endtask

    string      dir_text[] = '{
        "2024", "   ", "+2024-02-29T24:00Z", "-0001-12-31T23:59:59.999+23:59",
        "20240229T235960", "2024W527", "2024-W53", "2024-W01-8", "2024-366",
        "2024-000", "202412", "20241", "2024-13-01", "2024-01-32", "2024-01-15 10:30",
        "2024-01-15T10:30:15,5:00", "2024-01-15T24:00:01", "2024-01-15T12:00Z",
        "2024-06-01T12:00+24", "\t2024-06-01T1200z\n", "2024-06-01T", "1234567890",
        "2024-01-01T10:61",
        "0000000000000000000000000000000000000000000000000000000000000000000000"
    };
    int         dir_typed[] = '{1, 0, -1, -1, -1, -1, -1, -1, -1, -1, 0, -1, -1, -1, -1,
                               -1, -1, -1, -1, -1, -1, -1, -1, 2};

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (s_valid && s_ready) take_beat(cur_beat);
            if (!s_valid || s_ready) begin
                if (text_beats.size() > 0 && (calm || $urandom_range(0, 99) >= 14)) begin
                    cur_beat = text_beats.pop_front();
                    s_valid <= 1'b1;
                    s_text_byte <= cur_beat.b;
                    s_is_last <= cur_beat.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= calm || $urandom_range(0, 99) >= 14;
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $display("%0t unexpected verdict beat: valid=%0d overflow=%0d",
                             $time, m_is_valid, m_overflow);
                    fails++;
                end else begin
                    verdict_t vd;
                    vd = expected_verdicts.pop_front();
                    if (m_is_valid !== vd.valid || m_overflow !== vd.ovf) begin
                        $display("%0t verdict mismatch: exp valid=%0d ovf=%0d, got valid=%0d ovf=%0d",
                                 $time, vd.valid, vd.ovf, m_is_valid, m_overflow);
                        fails++;
                    end
                end
            end
        end
    end

    assign calm = cyc >= 4000 && cyc < 8000;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) stall_cnt <= 0;
        else stall_cnt <= stall_cnt + 1;
        if (stall_cnt == STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int total;
        foreach (dir_text[r]) begin
            txt.delete();
            for (int k = 0; k < dir_text[r].len(); k++) txt.push_back(dir_text[r][k]);
            queue_text(dir_typed[r]);
        end
        total = text_beats.size();
        while (total < 1150) begin
            case ($urandom_range(0, 19))
                0: begin
                    txt.delete();
                    repeat ($urandom_range(1, 10)) txt.push_back(8'($urandom_range(0, 255)));
                end
                1: begin
                    txt.delete();
                    repeat ($urandom_range(STORE_LEN + 1, STORE_LEN + 16))
                        txt.push_back(8'($urandom_range(0, 255)));
                end
                default: make_stamp();
            endcase
            total += txt.size();
            queue_text(-1);
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        while (text_beats.size() > 0 || s_valid || expected_verdicts.size() > 0)
            @(posedge aclk);
        repeat (500) @(posedge aclk);
        if (fails == 0 && expected_verdicts.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/itv_pkg.sv
hdl/itv_dp.sv
hdl/itv_ctrl.sv
hdl/iso8601_timestamp_validator.sv
test/tb_top.sv
